@@ design/sidiv_pkg.sv @@
// Shared width, constants and pipeline stage payload type for the signed divider.
package sidiv_pkg;

  // Operand and quotient width
  localparam int unsigned DataWidth = 32;

  // Largest positive quotient, used when the result overflows
  localparam logic [DataWidth-1:0] MaxPos = {1'b0, {(DataWidth-1){1'b1}}};

  // Payload carried from cell to cell along the divider chain
  typedef struct packed {
    logic [DataWidth-1:0] rem;   // partial remainder
    logic [DataWidth-1:0] nq;    // dividend bits still to use, quotient bits shifted in
    logic [DataWidth-1:0] dmag;  // divisor magnitude
    logic                 neg;   // quotient is negative
    logic                 dbz;   // divisor was zero
  } stage_t;

endpackage

@@ design/signed_int_divider_truncating.sv @@
// Stages: one prep stage, one cell per quotient bit, one fix-up stage, each registered.
// Throughput: one request per cycle while in_stall_o is low.
// A skid register at the output lets the chain move while a result waits to be taken.
// While the skid register is full the whole chain holds and in_stall_o is high.
// Reset (rst_ni, async, active low) clears all valid flags; no payload is reset.
module signed_int_divider_truncating (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [sidiv_pkg::DataWidth-1:0] numerator_i,
  input  logic signed [sidiv_pkg::DataWidth-1:0] denominator_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [sidiv_pkg::DataWidth-1:0] quotient_o,
  output logic                                   saturated_o,
  output logic                                   divide_by_zero_o
);

  localparam int unsigned W = sidiv_pkg::DataWidth;

  logic              en;
  logic              vld   [W+1];
  sidiv_pkg::stage_t stage [W+1];

  logic              post_vld_q;
  logic [W-1:0]      post_q_q, post_q_d;
  logic              post_sat_q, post_sat_d;
  logic              post_dbz_q, post_dbz_d;

  logic              skid_full_q, skid_full_d;
  logic [W-1:0]      skid_q_q;
  logic              skid_sat_q, skid_dbz_q;
  logic              skid_load;
  logic [W-1:0]      qmag;

  // The chain moves whenever the skid register has room
  assign en         = ~skid_full_q;
  assign in_stall_o = skid_full_q;

  // Operand folding
  sidiv_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (in_valid_i),
    .numerator_i   (numerator_i),
    .denominator_i (denominator_i),
    .vld_o         (vld[0]),
    .stage_o       (stage[0])
  );

  // Chain of restoring cells, most significant quotient bit first
  for (genvar i = 0; i < W; i++) begin : g_cell
    sidiv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (vld[i]),
      .stage_i (stage[i]),
      .vld_o   (vld[i+1]),
      .stage_o (stage[i+1])
    );
  end

  // Sign restore, saturation and divide-by-zero override
  assign qmag = stage[W].nq;

  always_comb begin
    post_sat_d = 1'b0;
    post_dbz_d = 1'b0;
    if (stage[W].dbz) begin
      post_q_d   = '0;
      post_dbz_d = 1'b1;
    end else if (stage[W].neg) begin
      post_q_d = ~qmag + 1'b1;
    end else if (qmag[W-1]) begin
      post_q_d   = sidiv_pkg::MaxPos;
      post_sat_d = 1'b1;
    end else begin
      post_q_d = qmag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= 1'b0;
    end else if (en) begin
      post_vld_q <= vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      post_q_q   <= post_q_d;
      post_sat_q <= post_sat_d;
      post_dbz_q <= post_dbz_d;
    end
  end

  // Skid register: catches the fix-up result when the consumer stalls
  assign skid_load = en & post_vld_q & out_stall_i;

  always_comb begin
    skid_full_d = skid_full_q;
    if (skid_full_q) begin
      if (!out_stall_i) begin
        skid_full_d = 1'b0;
      end
    end else if (skid_load) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_load) begin
      skid_q_q   <= post_q_q;
      skid_sat_q <= post_sat_q;
      skid_dbz_q <= post_dbz_q;
    end
  end

  // Output selection
  assign out_valid_o      = skid_full_q | post_vld_q;
  assign quotient_o       = skid_full_q ? skid_q_q   : post_q_q;
  assign saturated_o      = skid_full_q ? skid_sat_q : post_sat_q;
  assign divide_by_zero_o = skid_full_q ? skid_dbz_q : post_dbz_q;

  // A full skid register always presents a result
  a_skid_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_o)
    else $error("skid register full without output valid");

  // A taken skid result frees the register on the next cycle
  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && !out_stall_i |=> !skid_full_q)
    else $error("skid register not drained");

  // The two flags are exclusive
  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(saturated_o && divide_by_zero_o))
    else $error("saturated and divide_by_zero both set");

  // A saturated result is the largest positive value
  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> quotient_o == sidiv_pkg::MaxPos)
    else $error("saturated result is not the largest positive value");

  // A zero divisor gives a zero quotient
  a_dbz_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> quotient_o == '0)
    else $error("divide by zero result is not zero");

endmodule

@@ design/sidiv_prep.sv @@
// Front stage: folds both operands to unsigned magnitudes and records the signs.
module sidiv_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [sidiv_pkg::DataWidth-1:0] numerator_i,
  input  logic signed [sidiv_pkg::DataWidth-1:0] denominator_i,
  output logic                                vld_o,
  output sidiv_pkg::stage_t                   stage_o
);

  logic              vld_q;
  sidiv_pkg::stage_t stage_d, stage_q;
  logic [sidiv_pkg::DataWidth-1:0] nmag, dmag;

  // Two's complement magnitudes; the most negative value maps to 2^(W-1) unsigned
  assign nmag = numerator_i[sidiv_pkg::DataWidth-1]
                ? (~numerator_i + 1'b1) : numerator_i;
  assign dmag = denominator_i[sidiv_pkg::DataWidth-1]
                ? (~denominator_i + 1'b1) : denominator_i;

  always_comb begin
    stage_d.rem  = '0;
    stage_d.nq   = nmag;
    stage_d.dmag = dmag;
    stage_d.neg  = numerator_i[sidiv_pkg::DataWidth-1]
                   ^ denominator_i[sidiv_pkg::DataWidth-1];
    stage_d.dbz  = (denominator_i == '0);
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;

endmodule

@@ design/sidiv_cell.sv @@
// One divider cell: a single restoring step that yields one quotient bit.
module sidiv_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  sidiv_pkg::stage_t stage_i,
  output logic              vld_o,
  output sidiv_pkg::stage_t stage_o
);

  logic              vld_q;
  sidiv_pkg::stage_t stage_d, stage_q;
  logic [sidiv_pkg::DataWidth:0] trial;
  logic [sidiv_pkg::DataWidth:0] diff;

  // Shift the next dividend bit into the remainder and try the subtract
  assign trial = {stage_i.rem, stage_i.nq[sidiv_pkg::DataWidth-1]};
  assign diff  = trial - {1'b0, stage_i.dmag};

  always_comb begin
    stage_d = stage_i;
    if (!diff[sidiv_pkg::DataWidth]) begin
      stage_d.rem = diff[sidiv_pkg::DataWidth-1:0];
      stage_d.nq  = {stage_i.nq[sidiv_pkg::DataWidth-2:0], 1'b1};
    end else begin
      stage_d.rem = trial[sidiv_pkg::DataWidth-1:0];
      stage_d.nq  = {stage_i.nq[sidiv_pkg::DataWidth-2:0], 1'b0};
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the truncating signed divider: directed table, then random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = sidiv_pkg::DataWidth;
  localparam logic [W-1:0] MaxPos = sidiv_pkg::MaxPos;
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] AllOnes = {W{1'b1}};
  localparam int unsigned Latency = sidiv_pkg::DataWidth + 2;
  localparam int unsigned LongHold = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemsPerPhase = 400;

  // One division request; the typed flag marks an expected result written by hand
  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         typed;
    logic [W-1:0] quot;
    logic         sat;
    logic         dbz;
  } div_case_t;

  typedef struct packed {
    logic [W-1:0] quot;
    logic         sat;
    logic         dbz;
  } div_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [W-1:0] numerator_i = '0;
  logic signed [W-1:0] denominator_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [W-1:0] quotient_o;
  logic                saturated_o;
  logic                divide_by_zero_o;

  div_case_t   division_requests [$];
  div_result_t quotients_due [$];
  div_result_t offered_result;
  div_case_t   next_request;
  div_result_t oldest_due;

  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 74;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  // Directed requests: extremes, overflow, zero divisor, sign combinations
  div_case_t directed_cases [0:21] = '{
    '{MinNeg,  AllOnes, 1'b1, MaxPos,     1'b1, 1'b0},
    '{MinNeg,  0,       1'b1, 0,          1'b0, 1'b1},
    '{0,       0,       1'b1, 0,          1'b0, 1'b1},
    '{MaxPos,  0,       1'b1, 0,          1'b0, 1'b1},
    '{AllOnes, 0,       1'b1, 0,          1'b0, 1'b1},
    '{0,       5,       1'b1, 0,          1'b0, 1'b0},
    '{0,       MinNeg,  1'b1, 0,          1'b0, 1'b0},
    '{MaxPos,  1,       1'b1, MaxPos,     1'b0, 1'b0},
    '{MinNeg,  1,       1'b1, MinNeg,     1'b0, 1'b0},
    '{MaxPos,  AllOnes, 1'b1, MinNeg + 1, 1'b0, 1'b0},
    '{MinNeg,  MinNeg,  1'b1, 1,          1'b0, 1'b0},
    '{MaxPos,  MaxPos,  1'b1, 1,          1'b0, 1'b0},
    '{MinNeg,  MaxPos,  1'b1, AllOnes,    1'b0, 1'b0},
    '{MaxPos,  MinNeg,  1'b1, 0,          1'b0, 1'b0},
    '{7,       2,       1'b0, 0,          1'b0, 1'b0},
    '{-7,      2,       1'b0, 0,          1'b0, 1'b0},
    '{7,       -2,      1'b0, 0,          1'b0, 1'b0},
    '{-7,      -2,      1'b0, 0,          1'b0, 1'b0},
    '{5,       7,       1'b0, 0,          1'b0, 1'b0},
    '{MinNeg,  -2,      1'b0, 0,          1'b0, 1'b0},
    '{AllOnes, AllOnes, 1'b0, 0,          1'b0, 1'b0},
    '{MaxPos,  2,       1'b0, 0,          1'b0, 1'b0}
  };

  signed_int_divider_truncating dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .numerator_i     (numerator_i),
    .denominator_i   (denominator_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .saturated_o     (saturated_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always #5 clk_i = ~clk_i;

  // Truncating signed quotient via magnitudes, with overflow and zero-divisor flags
  function automatic div_result_t divide_truncating(logic [W-1:0] num, logic [W-1:0] den);
    logic [W-1:0] nmag, dmag, q;
    logic         nneg, dneg;
    div_result_t  r;
    nneg = num[W-1];
    dneg = den[W-1];
    nmag = nneg ? W'(-num) : num;
    dmag = dneg ? W'(-den) : den;
    r = '0;
    if (dmag == '0) begin
      r.dbz = 1'b1;
    end else begin
      q = nmag / dmag;
      if (nneg != dneg) begin
        r.quot = W'(-q);
      end else if (q[W-1]) begin
        r.quot = MaxPos;
        r.sat  = 1'b1;
      end else begin
        r.quot = q;
      end
    end
    return r;
  endfunction

  // Operand drawn from a mix of full-range, small, boundary and power-of-two values
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    case ($urandom_range(9))
      4: v = W'(int'($urandom_range(30)) - 15);
      5: begin
        case ($urandom_range(6))
          0: v = MinNeg;
          1: v = MinNeg + 1;
          2: v = AllOnes;
          3: v = '0;
          4: v = 1;
          5: v = MaxPos - 1;
          default: v = MaxPos;
        endcase
      end
      6: begin
        v = W'(1) << $urandom_range(W - 1);
        if ($urandom_range(1)) v = W'(-v);
      end
      7: begin
        v = W'($urandom);
        v = v >> $urandom_range(W - 1);
        if ($urandom_range(1)) v = ~v;
      end
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_random(int unsigned count);
    div_case_t c;
    for (int unsigned i = 0; i < count; i++) begin
      c = '0;
      c.num = random_operand();
      case ($urandom_range(19))
        0: c.den = c.num;
        1: c.den = W'(-c.num);
        2: c.den = c.num >> $urandom_range(W - 1);
        default: c.den = random_operand();
      endcase
      division_requests.push_back(c);
    end
  endtask

  // Wait until every request has gone in and every result has come back;
  // sampled at the falling edge so the queues and handshakes have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (division_requests.size() != 0 || in_valid_i || quotients_due.size() != 0)
      @(negedge clk_i);
    repeat (Latency + 6) @(posedge clk_i);
  endtask

  // Request side: hold while stalled, otherwise offer the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) quotients_due.push_back(offered_result);
      if (!in_valid_i || !in_stall_o) begin
        if (division_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_request = division_requests.pop_front();
          in_valid_i    <= 1'b1;
          numerator_i   <= next_request.num;
          denominator_i <= next_request.den;
          if (next_request.typed)
            offered_result <= '{next_request.quot, next_request.sat, next_request.dbz};
          else
            offered_result <= divide_truncating(next_request.num, next_request.den);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: check against the oldest expectation, then choose the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (quotients_due.size() == 0) begin
          $error("unexpected result: quotient %0d", quotient_o);
          errors++;
        end else begin
          oldest_due = quotients_due.pop_front();
          if (quotient_o !== oldest_due.quot) begin
            $error("quotient: expected %0d, actual %0d", $signed(oldest_due.quot), quotient_o);
            errors++;
          end
          if (saturated_o !== oldest_due.sat) begin
            $error("saturated: expected %0b, actual %0b", oldest_due.sat, saturated_o);
            errors++;
          end
          if (divide_by_zero_o !== oldest_due.dbz) begin
            $error("divide_by_zero: expected %0b, actual %0b", oldest_due.dbz,
                   divide_by_zero_o);
            errors++;
          end
        end
      end
      // long hold-off, counted here so the pipeline backs up into the input
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_cases[i]) division_requests.push_back(directed_cases[i]);
    wait_drained();

    // sender lightly idle, receiver mostly stalled
    queue_random(ItemsPerPhase);
    wait_drained();

    // roles swapped
    send_idle_pct = 74;
    recv_idle_pct = 13;
    queue_random(ItemsPerPhase);
    wait_drained();

    // no idling; one long hold-off, then a full pause of the sender
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(ItemsPerPhase / 2);
    repeat (20) @(posedge clk_i);
    hold_requests++;
    wait_drained();
    queue_random(ItemsPerPhase / 2);
    wait_drained();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
